// File: hw/rtl/msm_pkg.sv
// Shared types and constants for the multi-pattern stream matcher.
// Used by msm_cell and the top level; depends on nothing else.
`default_nettype none

package msm_pkg;

    localparam int CHAR_W    = 8;
    localparam int PROG_W    = 4;
    localparam int LEN_W     = 4;
    localparam int ID_W      = 8;
    localparam int SLOT_W    = 2;
    localparam int REG_SLOTS = 4;
    localparam int TEXT_W    = 64;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int COUNT_W   = 3;
    localparam int OUT_W     = 16;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COUNT   = 3'd0,
        REG_TEXT0   = 3'd1,
        REG_TEXT1   = 3'd2,
        REG_TEXT2   = 3'd3,
        REG_TEXT3   = 3'd4,
        REG_LENGTHS = 3'd5,
        REG_IDS     = 3'd6
    } cfg_reg_t;

    // Control handed into each cell along the row.
    typedef struct packed {
        logic step;    // a request is accepted this cycle
        logic active;  // slot lies below the configured count
        logic kill;    // an earlier slot completed on this character
    } cell_ctrl_t;

    // Status handed out of each cell to its neighbor and the result logic.
    typedef struct packed {
        logic hit;     // this slot completed on this character
        logic kill;    // this slot or an earlier one completed
    } cell_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/msm_cell.sv
// One matcher cell: holds the progress of one pattern slot.
// Depends on msm_pkg; instantiated in a row by the top level.
`default_nettype none

module msm_cell
    import msm_pkg::*;
#(
    parameter int MAX_PATTERN_LEN = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic [CHAR_W-1:0] in_char,
    input  wire logic [TEXT_W-1:0] pat_text,
    input  wire logic [LEN_W-1:0]  pat_len,
    output cell_stat_t             stat
);

    logic [PROG_W-1:0] prog_reg;
    logic [PROG_W-1:0] prog_next;
    logic [PROG_W-1:0] prog_inc;
    logic [CHAR_W-1:0] exp_char;
    logic              len_ok;
    logic              hit;

    assign len_ok   = (pat_len != '0) && (pat_len <= LEN_W'(MAX_PATTERN_LEN));
    assign prog_inc = PROG_W'(prog_reg + PROG_W'(1));
    // Only progress values below an enabled length (at most MAX_PATTERN_LEN) select a byte.
    assign exp_char = pat_text[{prog_reg[2:0], 3'b000} +: CHAR_W];

    always_comb
    begin
        hit       = 1'b0;
        prog_next = prog_reg;
        if (ctrl.step && ctrl.active && !ctrl.kill)
        begin
            if (!len_ok || (prog_reg >= pat_len))
            begin
                prog_next = '0;
            end
            else if (exp_char == in_char)
            begin
                if (prog_inc == pat_len)
                begin
                    hit       = 1'b1;
                    prog_next = '0;
                end
                else
                begin
                    prog_next = prog_inc;
                end
            end
            else
            begin
                prog_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_reg <= '0;
        end
        else
        begin
            prog_reg <= prog_next;
        end
    end

    assign stat.hit  = hit;
    assign stat.kill = ctrl.kill | hit;

endmodule

`default_nettype wire

// File: hw/rtl/multi_pattern_stream_matcher_unit.sv
// Multi-pattern stream matcher, top level: configuration registers, the row of
// msm_cell slots, and the output register. Depends on msm_pkg and msm_cell.
//
// Takes one character per request and returns one result per request. Every
// active slot cell compares the character in the same cycle; a completion
// travels down the row of cells so that the lowest completing slot wins and
// the slots after it keep their progress. A new character is taken every
// cycle while the output register is empty or being drained, and the result
// appears in the output register in the cycle after its request. There is no
// clearing pass after reset. At most four slots are backed by registers;
// NUM_SLOTS below four builds fewer cells.
`default_nettype none

module multi_pattern_stream_matcher_unit
    import msm_pkg::*;
#(
    parameter int NUM_SLOTS       = 4,
    parameter int MAX_PATTERN_LEN = 8
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Configuration write port.
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    // Input stream.
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [CHAR_W-1:0]    s_axis_tdata,   // [7:0] in_char
    // Result stream.
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [OUT_W-1:0]          m_axis_tdata    // [0] match_found, [8:1] match_id,
                                                      // [10:9] match_slot, [15:11] zero
);

    localparam int CELLS = (NUM_SLOTS < REG_SLOTS) ? NUM_SLOTS : REG_SLOTS;

    logic [COUNT_W-1:0]      count_reg;
    logic [TEXT_W-1:0]       text_reg [CELLS];
    logic [LEN_W*REG_SLOTS-1:0] len_reg;
    logic [ID_W*REG_SLOTS-1:0]  ids_reg;

    logic                    step;
    cell_ctrl_t              ctrl [CELLS];
    cell_stat_t              stat [CELLS];

    logic                    found;
    logic [ID_W-1:0]         id_sel;
    logic [SLOT_W-1:0]       slot_sel;

    logic                    out_valid_reg;
    logic [OUT_W-1:0]        out_data_reg;

    // Scalar configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            len_reg   <= '0;
            ids_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COUNT:   count_reg <= cfg_data[COUNT_W-1:0];
                REG_LENGTHS: len_reg   <= cfg_data[LEN_W*REG_SLOTS-1:0];
                REG_IDS:     ids_reg   <= cfg_data[ID_W*REG_SLOTS-1:0];
                default:     ;
            endcase
        end
    end

    assign step          = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;

    genvar s;
    generate
        for (s = 0; s < CELLS; s++)
        begin : g_slot
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    text_reg[s] <= '0;
                end
                else if (cfg_we && (cfg_index == CFG_IDX_W'(REG_TEXT0 + s)))
                begin
                    text_reg[s] <= cfg_data[TEXT_W-1:0];
                end
            end

            assign ctrl[s].step   = step;
            assign ctrl[s].active = (count_reg > COUNT_W'(s));
            if (s == 0)
            begin : g_first
                assign ctrl[s].kill = 1'b0;
            end
            else
            begin : g_next
                assign ctrl[s].kill = stat[s-1].kill;
            end

            msm_cell #(
                .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl[s]),
                .in_char  (s_axis_tdata),
                .pat_text (text_reg[s]),
                .pat_len  (len_reg[LEN_W*s +: LEN_W]),
                .stat     (stat[s])
            );
        end
    endgenerate

    // At most one cell hits, so the selections reduce to an OR.
    always_comb
    begin
        found    = 1'b0;
        id_sel   = '0;
        slot_sel = '0;
        for (int i = 0; i < CELLS; i++)
        begin
            if (stat[i].hit)
            begin
                found    = 1'b1;
                id_sel   = id_sel | ids_reg[ID_W*i +: ID_W];
                slot_sel = slot_sel | SLOT_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= {{(OUT_W-1-ID_W-SLOT_W){1'b0}}, slot_sel, id_sel, found};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

// File: hw/rtl/msm_checker.sv
// Port-level checks for the multi-pattern stream matcher, bound to the top level.
// Depends on multi_pattern_stream_matcher_unit port names only.
`default_nettype none

module msm_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Every accepted request produces a result in the next cycle.
    a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted request left no result");

    // A result only appears after a request was accepted.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("result without request");

    // Without a match, identifier and slot read zero.
    a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> (m_axis_tdata[15:1] == 15'd0))
        else $error("nonzero fields without a match");

    // An empty output register never blocks the input.
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind multi_pattern_stream_matcher_unit msm_checker u_msm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
